[rtl/core/swcr_pkg.sv]
// Shared widths, codes and unit handshake types of the sliding-window clock regression.
package swcr_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  localparam int T_W    = 62;
  localparam int FD_W   = 20;
  localparam int X_W    = 24;
  localparam int Y_W    = 32;
  localparam int CORR_W = 21;
  localparam int RES_W  = 63;
  localparam int WL_W   = 5;
  localparam int SP_W   = 11;

  localparam int SX_W   = 29;
  localparam int SY_W   = 37;
  localparam int SXY_W  = 61;
  localparam int SXX_W  = 53;

  localparam int K_W    = 55;
  localparam int NUM_W  = 66;
  localparam int Q_W    = 83;
  localparam int E_W    = 85;

  // serial multiplier: signed A times unsigned B, one bit of B per cycle
  localparam int MUL_A_W   = 82;
  localparam int MUL_B_W   = 30;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // serial restoring divider: one quotient bit per cycle
  localparam int DIV_N_W   = 82;
  localparam int DIV_D_W   = 58;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam int KDIV = 1000;

  typedef enum logic [1:0] {
    OP_WALL  = 2'd0,
    OP_PHASE = 2'd1,
    OP_CORR  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_SYNC_PERIOD   = 2'd1,
    CFG_WALL_BASE     = 2'd2,
    CFG_KERNEL_BASE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quo;
    logic [DIV_D_W-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/core/sliding_window_clock_regression.sv]
// Top level: sequencer, window store and running sums of the clock regression.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    operation, times, frame, sequence, correction
//  out_     output     out_valid/out_ready  result_time, fit_valid, held_count
//  cfg_     input      cfg_we               cfg_index, cfg_wdata (no wait, no read-back)
//
// One item at a time. The shared serial multiplier forms every product and the serial
// divider every quotient. A clear empties the window; a correction rewrites each held
// pair with one product; a sample takes one divide, two products per dropped pair and two
// for the push, then five products and one divide when a fit runs, or two products when
// the fit is degenerate and the slope is zero.
// Reset is synchronous; it empties the window and loads the register defaults.
// A finished result sits in the output register; the next item is accepted while it waits,
// and the sequencer stalls in its final state only if a second result would overwrite it.
module sliding_window_clock_regression import swcr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [T_W-1:0]          cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic [T_W-1:0]          in_first_time,
  input  logic [T_W-1:0]          in_second_time,
  input  logic [FD_W-1:0]         in_frame_duration,
  input  logic [X_W-1:0]          in_sequence_number,
  input  logic signed [CORR_W-1:0] in_correction,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RES_W-1:0] out_result_time,
  output logic                    out_fit_valid,
  output logic [4:0]              out_held_count
);

  typedef enum logic [29:0] {
    S_IDLE   = 30'h0000_0001,
    S_PREP   = 30'h0000_0002,
    S_PREP2  = 30'h0000_0004,
    S_XSTART = 30'h0000_0008,
    S_XDIV   = 30'h0000_0010,
    S_YNEW   = 30'h0000_0020,
    S_CHK    = 30'h0000_0040,
    S_DRD    = 30'h0000_0080,
    S_DM1    = 30'h0000_0100,
    S_DM2    = 30'h0000_0200,
    S_PUSH   = 30'h0000_0400,
    S_PM1    = 30'h0000_0800,
    S_PM2    = 30'h0000_1000,
    S_FIT0   = 30'h0000_2000,
    S_FA     = 30'h0000_4000,
    S_FB     = 30'h0000_8000,
    S_FCMP   = 30'h0001_0000,
    S_FP1    = 30'h0002_0000,
    S_FP2    = 30'h0004_0000,
    S_FNUM   = 30'h0008_0000,
    S_FM     = 30'h0010_0000,
    S_FDS    = 30'h0020_0000,
    S_FDIV   = 30'h0040_0000,
    S_FRES1  = 30'h0080_0000,
    S_FRES2  = 30'h0100_0000,
    S_CCHK   = 30'h0200_0000,
    S_CRD    = 30'h0400_0000,
    S_CWR    = 30'h0800_0000,
    S_CM     = 30'h1000_0000,
    S_DONE   = 30'h2000_0000
  } state_t;

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // saturate a 64-bit signed value to the 32-bit offset range
  function automatic logic signed [Y_W-1:0] sat_y(input logic signed [63:0] v);
    logic hi_same;
    hi_same = (&v[63:Y_W-1]) | ~(|v[63:Y_W-1]);
    if (hi_same) begin
      sat_y = v[Y_W-1:0];
    end else begin
      sat_y = v[63] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
    end
  endfunction

  // saturate the extrapolated sum to the 63-bit result range
  function automatic logic signed [RES_W-1:0] clamp_res(input logic signed [E_W-1:0] v);
    logic hi_same;
    hi_same = (&v[E_W-1:RES_W-1]) | ~(|v[E_W-1:RES_W-1]);
    if (hi_same) begin
      clamp_res = v[RES_W-1:0];
    end else begin
      clamp_res = v[E_W-1] ? RES_MIN : RES_MAX;
    end
  endfunction

  state_t                    state_r, state_nxt;
  logic [WL_W-1:0]           wl_r, wl_nxt;
  logic [SP_W-1:0]           sp_r, sp_nxt;
  logic [T_W-1:0]            wcb_r, wcb_nxt;
  logic [T_W-1:0]            ktb_r, ktb_nxt;

  op_t                       op_r, op_nxt;
  logic [T_W-1:0]            t1_r, t1_nxt;
  logic [T_W-1:0]            t2_r, t2_nxt;
  logic [FD_W-1:0]           fd_r, fd_nxt;
  logic [X_W-1:0]            seq_r, seq_nxt;
  logic signed [CORR_W-1:0]  corr_r, corr_nxt;

  logic [IDX_W-1:0]          oldest_r, oldest_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [SX_W-1:0]           sx_r, sx_nxt;
  logic signed [SY_W-1:0]    sy_r, sy_nxt;
  logic signed [SXY_W-1:0]   sxy_r, sxy_nxt;
  logic [SXX_W-1:0]          sxx_r, sxx_nxt;

  logic signed [T_W:0]       diff_r, diff_nxt;
  logic signed [T_W:0]       tw_r, tw_nxt;
  logic signed [63:0]        x_r, x_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [K_W-1:0]     k_r, k_nxt;
  logic [FD_W-1:0]           rmod_r, rmod_nxt;
  logic signed [Y_W-1:0]     ynew_r, ynew_nxt;
  logic [X_W-1:0]            xcur_r, xcur_nxt;
  logic signed [Y_W-1:0]     ycur_r, ycur_nxt;
  logic signed [Y_W-1:0]     base_r, base_nxt;
  logic [DIV_D_W-1:0]        a_r, a_nxt;
  logic [DIV_D_W-1:0]        b_r, b_nxt;
  logic [DIV_D_W-1:0]        den_r, den_nxt;
  logic signed [NUM_W-1:0]   p1_r, p1_nxt;
  logic signed [NUM_W-1:0]   num_r, num_nxt;
  logic signed [DIV_N_W-1:0] numm_r, numm_nxt;
  logic signed [Q_W-1:0]     q_r, q_nxt;
  logic signed [63:0]        kw_r, kw_nxt;
  logic signed [E_W-1:0]     e_r, e_nxt;
  logic signed [RES_W-1:0]   res_r, res_nxt;
  logic                      fitv_r, fitv_nxt;
  logic [CNT_W-1:0]          walk_r, walk_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [RES_W-1:0]   out_res_r, out_res_nxt;
  logic                      out_fit_r, out_fit_nxt;
  logic [4:0]                out_cnt_r, out_cnt_nxt;

  logic signed [Y_W-1:0]     off_mem [MAX_WINDOW];
  logic [X_W-1:0]            seq_mem [MAX_WINDOW];
  logic signed [Y_W-1:0]     rd_off_r;
  logic [X_W-1:0]            rd_seq_r;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [IDX_W-1:0]          mem_raddr;
  logic signed [Y_W-1:0]     mem_woff;
  logic [X_W-1:0]            mem_wseq;

  mul_req_t                  mul_req;
  mul_rsp_t                  mul_rsp;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  logic [FD_W-1:0]           fdv;
  logic [FD_W-1:0]           half;
  logic [CNT_W-1:0]          wl_eff;
  logic signed [63:0]        x_abs;
  logic signed [DIV_N_W-1:0] numm_abs;
  logic [15:0]               ext_span;
  logic signed [E_W-1:0]     e_tot;
  logic signed [63:0]        yk;
  logic signed [FD_W:0]      yph;
  logic signed [Y_W:0]       ycorr;
  logic [DIV_N_W-1:0]        qmag;

  swcr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  swcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // zero frame duration acts as one
  assign fdv  = (fd_r == '0) ? FD_W'(1) : fd_r;
  assign half = fdv >> 1;

  // window length: zero acts as one, beyond the store acts as the store depth
  always_comb begin
    if (wl_r == '0) begin
      wl_eff = CNT_W'(1);
    end else if (CNT_W'(wl_r) > CNT_W'(MAX_WINDOW)) begin
      wl_eff = CNT_W'(MAX_WINDOW);
    end else begin
      wl_eff = CNT_W'(wl_r);
    end
  end

  assign x_abs    = x_r[63] ? -x_r : x_r;
  assign numm_abs = numm_r[DIV_N_W-1] ? -numm_r : numm_r;
  assign ext_span = 16'(cnt_r - 1'b1) * 16'(sp_r);
  assign e_tot    = e_r + ((op_r == OP_WALL) ? E_W'(kw_r) : E_W'(0));
  assign yk       = 64'(tw_r) - 64'(k_r);
  assign yph      = $signed({1'b0, rmod_r}) - $signed({1'b0, half});
  assign ycorr    = (Y_W+1)'(rd_off_r) - (Y_W+1)'(corr_r);
  assign qmag     = div_rsp.quo;

  assign mem_raddr = (state_r == S_CCHK) ? oldest_r + walk_r[IDX_W-1:0] : oldest_r;

  always_comb begin
    state_nxt     = state_r;
    wl_nxt        = wl_r;
    sp_nxt        = sp_r;
    wcb_nxt       = wcb_r;
    ktb_nxt       = ktb_r;
    op_nxt        = op_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    fd_nxt        = fd_r;
    seq_nxt       = seq_r;
    corr_nxt      = corr_r;
    oldest_nxt    = oldest_r;
    cnt_nxt       = cnt_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sxy_nxt       = sxy_r;
    sxx_nxt       = sxx_r;
    diff_nxt      = diff_r;
    tw_nxt        = tw_r;
    x_nxt         = x_r;
    neg_nxt       = neg_r;
    k_nxt         = k_r;
    rmod_nxt      = rmod_r;
    ynew_nxt      = ynew_r;
    xcur_nxt      = xcur_r;
    ycur_nxt      = ycur_r;
    base_nxt      = base_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    den_nxt       = den_r;
    p1_nxt        = p1_r;
    num_nxt       = num_r;
    numm_nxt      = numm_r;
    q_nxt         = q_r;
    kw_nxt        = kw_r;
    e_nxt         = e_r;
    res_nxt       = res_r;
    fitv_nxt      = fitv_r;
    walk_nxt      = walk_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_fit_nxt   = out_fit_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = oldest_r + cnt_r[IDX_W-1:0];
    mem_woff      = ynew_r;
    mem_wseq      = seq_r;
    mul_req.start = 1'b0;
    mul_req.a     = MUL_A_W'(xcur_r);
    mul_req.b     = MUL_B_W'(xcur_r);
    div_req.start = 1'b0;
    div_req.num   = DIV_N_W'($unsigned(x_abs));
    div_req.den   = DIV_D_W'(KDIV);

    // apply configuration writes; the host must issue them only while idle (not enforced here)
    if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH: wl_nxt  = cfg_wdata[WL_W-1:0];
        CFG_SYNC_PERIOD:   sp_nxt  = cfg_wdata[SP_W-1:0];
        CFG_WALL_BASE:     wcb_nxt = cfg_wdata;
        CFG_KERNEL_BASE:   ktb_nxt = cfg_wdata;
        default: ;
      endcase
    end

    // drop the shown result once the consumer takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = op_t'(in_operation);
          t1_nxt   = in_first_time;
          t2_nxt   = in_second_time;
          fd_nxt   = in_frame_duration;
          seq_nxt  = in_sequence_number;
          corr_nxt = in_correction;
          res_nxt  = '0;
          fitv_nxt = 1'b0;
          case (op_t'(in_operation))
            OP_WALL, OP_PHASE: state_nxt = S_PREP;
            OP_CORR: begin
              sy_nxt    = '0;
              sxy_nxt   = '0;
              walk_nxt  = '0;
              state_nxt = S_CCHK;
            end
            default: begin
              oldest_nxt = '0;
              cnt_nxt    = '0;
              sx_nxt     = '0;
              sy_nxt     = '0;
              sxy_nxt    = '0;
              sxx_nxt    = '0;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      // kernel time against its base, or local against reference wall clock
      S_PREP: begin
        if (op_r == OP_WALL) begin
          diff_nxt = $signed({1'b0, t2_r}) - $signed({1'b0, ktb_r});
        end else begin
          diff_nxt = $signed({1'b0, t2_r}) - $signed({1'b0, t1_r});
        end
        tw_nxt    = $signed({1'b0, t1_r}) - $signed({1'b0, wcb_r});
        state_nxt = S_PREP2;
      end

      S_PREP2: begin
        if (op_r == OP_WALL) begin
          x_nxt = 64'(diff_r);
        end else begin
          x_nxt = 64'(diff_r) + 64'(half);
        end
        state_nxt = S_XSTART;
      end

      S_XSTART: begin
        neg_nxt       = x_r[63];
        div_req.start = 1'b1;
        div_req.num   = DIV_N_W'($unsigned(x_abs));
        div_req.den   = (op_r == OP_WALL) ? DIV_D_W'(KDIV) : DIV_D_W'(fdv);
        state_nxt     = S_XDIV;
      end

      // truncating quotient for the kernel time, floor remainder for the phase
      S_XDIV: begin
        if (div_rsp.done) begin
          k_nxt = neg_r ? -$signed(qmag[K_W-1:0]) : $signed(qmag[K_W-1:0]);
          if (neg_r && (div_rsp.rem != '0)) begin
            rmod_nxt = fdv - div_rsp.rem[FD_W-1:0];
          end else begin
            rmod_nxt = div_rsp.rem[FD_W-1:0];
          end
          state_nxt = S_YNEW;
        end
      end

      S_YNEW: begin
        ynew_nxt  = (op_r == OP_WALL) ? sat_y(yk) : Y_W'(yph);
        state_nxt = S_CHK;
      end

      // evict oldest pairs until the new one fits
      S_CHK: begin
        if ((cnt_r >= wl_eff) && (cnt_r != '0)) begin
          state_nxt = S_DRD;
        end else begin
          state_nxt = S_PUSH;
        end
      end

      S_DRD: begin
        xcur_nxt      = rd_seq_r;
        ycur_nxt      = rd_off_r;
        sx_nxt        = sx_r - SX_W'(rd_seq_r);
        sy_nxt        = sy_r - SY_W'(rd_off_r);
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(rd_seq_r);
        mul_req.b     = MUL_B_W'(rd_seq_r);
        state_nxt     = S_DM1;
      end

      S_DM1: begin
        if (mul_rsp.done) begin
          sxx_nxt       = sxx_r - mul_rsp.product[SXX_W-1:0];
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(ycur_r);
          mul_req.b     = MUL_B_W'(xcur_r);
          state_nxt     = S_DM2;
        end
      end

      S_DM2: begin
        if (mul_rsp.done) begin
          sxy_nxt    = sxy_r - mul_rsp.product[SXY_W-1:0];
          oldest_nxt = oldest_r + 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
          state_nxt  = S_CHK;
        end
      end

      S_PUSH: begin
        mem_we        = 1'b1;
        xcur_nxt      = seq_r;
        ycur_nxt      = ynew_r;
        cnt_nxt       = cnt_r + 1'b1;
        sx_nxt        = sx_r + SX_W'(seq_r);
        sy_nxt        = sy_r + SY_W'(ynew_r);
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(seq_r);
        mul_req.b     = MUL_B_W'(seq_r);
        state_nxt     = S_PM1;
      end

      S_PM1: begin
        if (mul_rsp.done) begin
          sxx_nxt       = sxx_r + mul_rsp.product[SXX_W-1:0];
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(ycur_r);
          mul_req.b     = MUL_B_W'(xcur_r);
          state_nxt     = S_PM2;
        end
      end

      S_PM2: begin
        if (mul_rsp.done) begin
          sxy_nxt = sxy_r + mul_rsp.product[SXY_W-1:0];
          if ((op_r == OP_WALL) && (cnt_r <= CNT_W'(5))) begin
            res_nxt   = RES_W'(t1_r);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FIT0;
          end
        end
      end

      // fit: oldest offset plus slope times the extrapolation distance
      S_FIT0: begin
        base_nxt      = rd_off_r;
        kw_nxt        = 64'(k_r) + 64'(wcb_r);
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(sxx_r);
        mul_req.b     = MUL_B_W'(cnt_r);
        state_nxt     = S_FA;
      end

      S_FA: begin
        if (mul_rsp.done) begin
          a_nxt         = mul_rsp.product[DIV_D_W-1:0];
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(sx_r);
          mul_req.b     = MUL_B_W'(sx_r);
          state_nxt     = S_FB;
        end
      end

      S_FB: begin
        if (mul_rsp.done) begin
          b_nxt     = mul_rsp.product[DIV_D_W-1:0];
          state_nxt = S_FCMP;
        end
      end

      // degenerate fit: slope zero
      S_FCMP: begin
        den_nxt = a_r - b_r;
        if ((cnt_r < CNT_W'(2)) || (a_r <= b_r)) begin
          q_nxt     = '0;
          state_nxt = S_FRES1;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(sxy_r);
          mul_req.b     = MUL_B_W'(cnt_r);
          state_nxt     = S_FP1;
        end
      end

      S_FP1: begin
        if (mul_rsp.done) begin
          p1_nxt        = mul_rsp.product[NUM_W-1:0];
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(sy_r);
          mul_req.b     = MUL_B_W'(sx_r);
          state_nxt     = S_FP2;
        end
      end

      S_FP2: begin
        if (mul_rsp.done) begin
          num_nxt   = p1_r - mul_rsp.product[NUM_W-1:0];
          state_nxt = S_FNUM;
        end
      end

      S_FNUM: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(num_r);
        mul_req.b     = MUL_B_W'(ext_span);
        state_nxt     = S_FM;
      end

      S_FM: begin
        if (mul_rsp.done) begin
          numm_nxt  = mul_rsp.product[DIV_N_W-1:0];
          state_nxt = S_FDS;
        end
      end

      S_FDS: begin
        neg_nxt       = numm_r[DIV_N_W-1];
        div_req.start = 1'b1;
        div_req.num   = $unsigned(numm_abs);
        div_req.den   = den_r;
        state_nxt     = S_FDIV;
      end

      S_FDIV: begin
        if (div_rsp.done) begin
          q_nxt     = neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
          state_nxt = S_FRES1;
        end
      end

      S_FRES1: begin
        e_nxt     = E_W'(q_r) + E_W'(base_r);
        state_nxt = S_FRES2;
      end

      S_FRES2: begin
        res_nxt   = clamp_res(e_tot);
        fitv_nxt  = (op_r == OP_WALL);
        state_nxt = S_DONE;
      end

      // correction walk, oldest to newest
      S_CCHK: begin
        if (walk_r == cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CRD;
        end
      end

      S_CRD: begin
        ycur_nxt  = sat_y(64'(ycorr));
        xcur_nxt  = rd_seq_r;
        state_nxt = S_CWR;
      end

      S_CWR: begin
        mem_we        = 1'b1;
        mem_waddr     = oldest_r + walk_r[IDX_W-1:0];
        mem_woff      = ycur_r;
        mem_wseq      = xcur_r;
        sy_nxt        = sy_r + SY_W'(ycur_r);
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(ycur_r);
        mul_req.b     = MUL_B_W'(xcur_r);
        state_nxt     = S_CM;
      end

      S_CM: begin
        if (mul_rsp.done) begin
          sxy_nxt   = sxy_r + mul_rsp.product[SXY_W-1:0];
          walk_nxt  = walk_r + 1'b1;
          state_nxt = S_CCHK;
        end
      end

      // hold until the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_fit_nxt   = fitv_r;
          out_cnt_nxt   = 5'(cnt_r);
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= WL_W'(16);
      sp_r        <= SP_W'(1);
      wcb_r       <= '0;
      ktb_r       <= '0;
      oldest_r    <= '0;
      cnt_r       <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxy_r       <= '0;
      sxx_r       <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      sp_r        <= sp_nxt;
      wcb_r       <= wcb_nxt;
      ktb_r       <= ktb_nxt;
      oldest_r    <= oldest_nxt;
      cnt_r       <= cnt_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      sxy_r       <= sxy_nxt;
      sxx_r       <= sxx_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    t1_r      <= t1_nxt;
    t2_r      <= t2_nxt;
    fd_r      <= fd_nxt;
    seq_r     <= seq_nxt;
    corr_r    <= corr_nxt;
    diff_r    <= diff_nxt;
    tw_r      <= tw_nxt;
    x_r       <= x_nxt;
    neg_r     <= neg_nxt;
    k_r       <= k_nxt;
    rmod_r    <= rmod_nxt;
    ynew_r    <= ynew_nxt;
    xcur_r    <= xcur_nxt;
    ycur_r    <= ycur_nxt;
    base_r    <= base_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    den_r     <= den_nxt;
    p1_r      <= p1_nxt;
    num_r     <= num_nxt;
    numm_r    <= numm_nxt;
    q_r       <= q_nxt;
    kw_r      <= kw_nxt;
    e_r       <= e_nxt;
    res_r     <= res_nxt;
    fitv_r    <= fitv_nxt;
    out_res_r <= out_res_nxt;
    out_fit_r <= out_fit_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // window store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      off_mem[mem_waddr] <= mem_woff;
      seq_mem[mem_waddr] <= mem_wseq;
    end
    rd_off_r <= off_mem[mem_raddr];
    rd_seq_r <= seq_mem[mem_raddr];
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_time = out_res_r;
  assign out_fit_valid   = out_fit_r;
  assign out_held_count  = out_cnt_r;

endmodule

[rtl/core/swcr_mul.sv]
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
module swcr_mul import swcr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic signed [PROD_W-1:0] mcand_r, mcand_nxt;
  logic [MUL_B_W-1:0]       mplier_r, mplier_nxt;
  logic [MUL_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = PROD_W'(req.a);
      mplier_nxt = req.b;
      cnt_nxt    = MUL_CNT_W'(MUL_B_W - 1);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("multiplier started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r) else $error("multiplier done without a run");
`endif

endmodule

[rtl/core/swcr_div.sv]
// Serial restoring divider: one quotient bit per cycle, unsigned operands.
module swcr_div import swcr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_D_W:0]     rem_sh;
  logic [DIV_D_W:0]     rem_diff;
  logic                 fits;

  assign rem_sh   = {rem_r, quo_r[DIV_N_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign fits     = rem_sh >= {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = DIV_CNT_W'(DIV_N_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      quo_nxt = {quo_r[DIV_N_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

`ifndef SYNTH
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider started while busy");
`endif

endmodule

[dv/tb_sliding_window_clock_regression.sv]
// Self-checking testbench for the sliding-window clock regression block.
module tb_sliding_window_clock_regression;
  timeunit 1ns;
  timeprecision 1ps;
  import swcr_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int SETTLE_CYCLES = 600;
  localparam logic signed [127:0] RES_HI = (128'sd1 <<< 62) - 1;
  localparam logic signed [127:0] RES_LO = -(128'sd1 <<< 62);

  typedef struct {
    op_t                      op;
    logic [T_W-1:0]           t1;
    logic [T_W-1:0]           t2;
    logic [FD_W-1:0]          fd;
    logic [X_W-1:0]           sq;
    logic signed [CORR_W-1:0] corr;
  } sample_t;

  typedef struct {
    logic [RES_W-1:0] res;
    logic             fv;
    logic [4:0]       held;
  } fit_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [T_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [T_W-1:0] in_first_time = '0;
  logic [T_W-1:0] in_second_time = '0;
  logic [FD_W-1:0] in_frame_duration = '0;
  logic [X_W-1:0] in_sequence_number = '0;
  logic signed [CORR_W-1:0] in_correction = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RES_W-1:0] out_result_time;
  logic out_fit_valid;
  logic [4:0] out_held_count;

  sliding_window_clock_regression dut (.*);

  always #4 clk = ~clk;

  // Predictor copy of the window, the running sums and the registers
  logic signed [31:0] win_offset[MAX_WINDOW];
  logic [X_W-1:0] win_seq[MAX_WINDOW];
  int unsigned win_head, win_fill;
  logic [63:0] acc_x, acc_y, acc_xy, acc_xx;
  logic [4:0] reg_wl = 5'd16;
  logic [10:0] reg_sp = 11'd1;
  logic [T_W-1:0] reg_wb = '0, reg_kb = '0;

  sample_t pending_samples[$];
  fit_result_t expected_fits[$];
  int errors = 0;
  int cycles = 0;
  int accepted = 0, results_seen = 0, fits_seen = 0;
  logic in_taken = 1'b0;
  bit calm = 1'b0;

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
  endtask

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [RES_W-1:0] clamp63(logic [127:0] v);
    logic signed [127:0] s;
    s = v;
    if (s > RES_HI) return RES_HI[62:0];
    if (s < RES_LO) return RES_LO[62:0];
    return v[62:0];
  endfunction

  // Oldest offset plus the slope term, truncated once toward zero
  function automatic logic [127:0] line_extrapolate();
    logic [63:0] n, a, b;
    logic [127:0] base, num, mag, q;
    logic neg;
    n = win_fill;
    base = {{96{win_offset[win_head][31]}}, win_offset[win_head]};
    a = n * acc_xx;
    b = acc_x * acc_x;
    if (n < 2 || a <= b) return base;
    num = {{64{acc_xy[63]}}, acc_xy} * {64'd0, n} - {{64{acc_y[63]}}, acc_y} * {64'd0, acc_x};
    num = num * {64'd0, (n - 64'd1) * {53'd0, reg_sp}};
    neg = num[127];
    mag = neg ? -num : num;
    q = mag / {64'd0, a - b};
    return base + (neg ? -q : q);
  endfunction

  function automatic void drop_oldest();
    logic [63:0] x, y;
    x = {40'd0, win_seq[win_head]};
    y = {{32{win_offset[win_head][31]}}, win_offset[win_head]};
    acc_x -= x;
    acc_y -= y;
    acc_xy -= y * x;
    acc_xx -= x * x;
    win_head = (win_head + 1) % MAX_WINDOW;
    win_fill--;
  endfunction

  function automatic void push_pair(logic signed [31:0] y, logic [X_W-1:0] x);
    int unsigned wl, s;
    logic [63:0] xe, ye;
    wl = (reg_wl == 0) ? 1 : (reg_wl > MAX_WINDOW ? MAX_WINDOW : reg_wl);
    while (win_fill >= wl && win_fill > 0) drop_oldest();
    s = (win_head + win_fill) % MAX_WINDOW;
    win_offset[s] = y;
    win_seq[s] = x;
    win_fill++;
    xe = {40'd0, x};
    ye = {{32{y[31]}}, y};
    acc_x += xe;
    acc_y += ye;
    acc_xy += ye * xe;
    acc_xx += xe * xe;
  endfunction

  function automatic fit_result_t predict_fit(sample_t it);
    fit_result_t r;
    longint t1, t2, k, y, fdl, d, rm;
    logic signed [63:0] cv;
    logic signed [31:0] yy;
    int unsigned s;
    r.res = '0;
    r.fv = 1'b0;
    t1 = {2'b0, it.t1};
    t2 = {2'b0, it.t2};
    case (it.op)
      OP_WALL: begin
        k = (t2 - longint'({2'b0, reg_kb})) / 1000;
        y = (t1 - longint'({2'b0, reg_wb})) - k;
        push_pair(sat32(y), it.sq);
        if (win_fill > 5) begin
          r.res = clamp63(line_extrapolate() + {{64{k[63]}}, k} + {66'd0, reg_wb});
          r.fv = 1'b1;
        end else begin
          r.res = {1'b0, it.t1};
        end
      end
      OP_PHASE: begin
        fdl = (it.fd == 0) ? 1 : {44'd0, it.fd};
        d = t2 - t1;
        rm = (d + fdl / 2) % fdl;
        if (rm < 0) rm += fdl;
        y = rm - fdl / 2;
        push_pair(y[31:0], it.sq);
        r.res = clamp63(line_extrapolate());
      end
      OP_CORR: begin
        cv = it.corr;
        acc_y = '0;
        acc_xy = '0;
        for (int i = 0; i < win_fill; i++) begin
          s = (win_head + i) % MAX_WINDOW;
          yy = sat32(64'(win_offset[s]) - cv);
          win_offset[s] = yy;
          acc_y += 64'(yy);
          acc_xy += 64'(yy) * {40'd0, win_seq[s]};
        end
      end
      default: begin
        win_head = 0;
        win_fill = 0;
        acc_x = '0;
        acc_y = '0;
        acc_xy = '0;
        acc_xx = '0;
      end
    endcase
    r.held = win_fill[4:0];
    return r;
  endfunction

  // Driver: present a new transfer at the falling edge once the last one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
        sample_t it;
        it = pending_samples[0];
        pending_samples.delete(0);
        in_valid <= 1'b1;
        in_operation <= it.op;
        in_first_time <= it.t1;
        in_second_time <= it.t2;
        in_frame_duration <= it.fd;
        in_sequence_number <= it.sq;
        in_correction <= it.corr;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= calm || ($urandom_range(99) >= 32);
  end

  // Monitor: check results first, then predict for the transfer taken at this edge
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb_sliding_window_clock_regression failed");
        $finish;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_fits.size() == 0) begin
          report("unexpected result", out_result_time, 0);
        end else begin
          fit_result_t w;
          w = expected_fits[0];
          expected_fits.delete(0);
          if (out_fit_valid) fits_seen++;
          if (out_result_time !== w.res)
            report("result_time", out_result_time, $signed(w.res));
          if (out_fit_valid !== w.fv) report("fit_valid", out_fit_valid, w.fv);
          if (out_held_count !== w.held) report("held_count", out_held_count, w.held);
        end
      end
      if (in_valid && in_ready) begin
        sample_t it;
        it.op = op_t'(in_operation);
        it.t1 = in_first_time;
        it.t2 = in_second_time;
        it.fd = in_frame_duration;
        it.sq = in_sequence_number;
        it.corr = in_correction;
        expected_fits.insert(expected_fits.size(), predict_fit(it));
        accepted++;
      end
    end
  end

  function automatic logic [T_W-1:0] rand62();
    return T_W'({$urandom, $urandom});
  endfunction

  function automatic void add_sample(op_t op, logic [T_W-1:0] t1, logic [T_W-1:0] t2,
                                     logic [FD_W-1:0] fd, logic [X_W-1:0] sq,
                                     logic signed [CORR_W-1:0] corr);
    sample_t it;
    it.op = op;
    it.t1 = t1;
    it.t2 = t2;
    it.fd = fd;
    it.sq = sq;
    it.corr = corr;
    pending_samples.insert(pending_samples.size(), it);
  endfunction

  function automatic void add_noise();
    add_sample(op_t'($urandom_range(3)), rand62(), rand62(), FD_W'($urandom),
               X_W'($urandom), CORR_W'($urandom));
  endfunction

  // Wall clock pair whose offset lands near y_target
  function automatic void add_wall(logic [X_W-1:0] sq, longint y_target);
    longint t1, t2;
    t1 = longint'({2'b0, reg_wb}) + 64'd1000000000 + longint'(sq) * 33333;
    t2 = longint'({2'b0, reg_kb}) + (t1 - longint'({2'b0, reg_wb}) - y_target) * 1000
         + $urandom_range(999);
    add_sample(OP_WALL, t1[61:0], t2[61:0], FD_W'($urandom), sq, CORR_W'($urandom));
  endfunction

  // Well-formed sample streams with drifting offsets, plus some noise
  task automatic add_stream(int count);
    logic [X_W-1:0] sq;
    longint y0, drift;
    int pick;
    sq = X_W'($urandom);
    y0 = longint'($urandom_range(200000)) - 100000;
    drift = longint'($urandom_range(400)) - 200;
    for (int i = 0; i < count; i++) begin
      sq += X_W'($urandom_range(1, 3));
      pick = $urandom_range(99);
      if (pick < 70) begin
        add_wall(sq, y0 + drift * i + longint'($urandom_range(200)) - 100);
      end else if (pick < 85) begin
        logic [T_W-1:0] ref_t;
        ref_t = T_W'({$urandom_range(255), $urandom});
        add_sample(OP_PHASE, ref_t, T_W'(ref_t + $urandom_range(60000) - 30000),
                   FD_W'($urandom_range(1, 40000)), sq, CORR_W'($urandom));
      end else if (pick < 91) begin
        add_sample(OP_CORR, rand62(), rand62(), FD_W'($urandom), X_W'($urandom),
                   CORR_W'(int'($urandom_range(2000)) - 1000));
      end else if (pick < 93) begin
        add_sample(OP_CLEAR, rand62(), rand62(), FD_W'($urandom), X_W'($urandom),
                   CORR_W'($urandom));
      end else begin
        add_noise();
      end
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [T_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_WINDOW_LENGTH: reg_wl = value[4:0];
      CFG_SYNC_PERIOD:   reg_sp = value[10:0];
      CFG_WALL_BASE:     reg_wb = value;
      default:           reg_kb = value;
    endcase
    @(posedge clk);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every transfer is taken and every result is back
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_fits.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  logic [4:0] phase_wl[7] = '{5'd6, 5'd1, 5'd31, 5'd0, 5'd16, 5'd9, 5'd7};
  logic [10:0] phase_sp[7] = '{11'd30, 11'd0, 11'd2047, 11'd1, 11'd5, 11'd1024, 11'd3};

  initial begin
    win_head = 0;
    win_fill = 0;
    acc_x = '0;
    acc_y = '0;
    acc_xy = '0;
    acc_xx = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty window, frame extremes, correction extremes, fit onset, saturation
    add_sample(OP_CLEAR, '0, '0, '0, '0, '0);
    add_sample(OP_CORR, '0, '0, '0, '0, -21'sd1048576);
    add_sample(OP_PHASE, 62'd100, 62'd7, 20'd0, 24'd0, '0);
    add_sample(OP_PHASE, 62'd0, '1, 20'hFFFFF, 24'hFFFFFF, '0);
    add_sample(OP_WALL, '1, '0, 20'd1, 24'hFFFFFF, 21'sd1048575);
    add_sample(OP_WALL, '0, '1, 20'd1, 24'd0, '0);
    for (int i = 0; i < 8; i++) add_wall(24'd100 + 24'(i), 500 + 37 * i);
    add_sample(OP_CORR, '0, '0, '0, '0, 21'sd1048575);
    add_sample(OP_CORR, '0, '0, '0, '0, -21'sd1048576);
    add_sample(OP_WALL, '0, '0, 20'd1, 24'd50, '0);
    add_sample(OP_PHASE, 62'd1000, 62'd1017, 20'd33333, 24'd200, '0);
    add_sample(OP_CLEAR, '0, '0, '0, '0, '0);
    drain();

    // Random phases across register settings; one phase runs without idling
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_WINDOW_LENGTH, {57'd0, phase_wl[p]});
      write_reg(CFG_SYNC_PERIOD, {51'd0, phase_sp[p]});
      write_reg(CFG_WALL_BASE,
                p == 2 ? '1 : (p == 0 ? '0 : T_W'({$urandom_range(255), $urandom})));
      write_reg(CFG_KERNEL_BASE,
                p == 2 ? '1 : (p == 0 ? '0 : T_W'({$urandom_range(255), $urandom})));
      end_writes();
      calm = (p == 4);
      add_stream(100);
      drain();
    end
    calm = 1'b0;

    $display("covered %0d transfers, %0d results checked, %0d with a valid fit",
             accepted, results_seen, fits_seen);
    $display("seven register settings incl. window and period extremes, directed edge cases");
    if (errors == 0 && expected_fits.size() == 0) begin
      $display("tb_sliding_window_clock_regression passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_fits.size());
      $display("tb_sliding_window_clock_regression failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/swcr_pkg.sv
rtl/core/swcr_mul.sv
rtl/core/swcr_div.sv
rtl/core/sliding_window_clock_regression.sv
dv/tb_sliding_window_clock_regression.sv
